// ----- src/cap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cap_pkg;

  localparam int unsigned DISCARD_STEPS = 64;
  localparam int unsigned STEP_W        = $clog2(DISCARD_STEPS + 1);
  localparam int unsigned NUM_UOPS      = 12;
  localparam int unsigned UOP_W         = $clog2(NUM_UOPS);
  localparam int unsigned MIX_ROUNDS    = 4;
  localparam int unsigned RND_W         = $clog2(MIX_ROUNDS);
  localparam int unsigned ROT_A         = 7;
  localparam int unsigned ROT_B         = 13;

  localparam logic [63:0] DEF_NAN  = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QNAN_BIT = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {CFG_STEP, CFG_A, CFG_B, CFG_C} cfg_idx_e;
  typedef enum logic [1:0] {FOP_ADD, FOP_SUB, FOP_MUL, FOP_CVT} fpu_op_e;
  typedef enum logic [2:0] {
    SRC_X, SRC_Y, SRC_Z, SRC_T, SRC_H, SRC_A, SRC_B, SRC_C
  } src_e;
  typedef enum logic [1:0] {DST_X, DST_Y, DST_Z, DST_T} dst_e;

  typedef struct packed {
    fpu_op_e op;
    logic    neg_a;
    src_e    a;
    src_e    b;
    dst_e    dst;
  } uop_t;

  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  function automatic uop_t mk_uop(fpu_op_e op, logic neg_a, src_e a, src_e b, dst_e dst);
    uop_t u;
    u.op    = op;
    u.neg_a = neg_a;
    u.a     = a;
    u.b     = b;
    u.dst   = dst;
    return u;
  endfunction

  // one Euler step: x, then y with new x, then z with new x
  function automatic uop_t uop_at(logic [UOP_W-1:0] idx);
    uop_t u;
    case (idx)
      4'd0:    u = mk_uop(FOP_SUB, 1'b1, SRC_Y, SRC_Z, DST_T);
      4'd1:    u = mk_uop(FOP_MUL, 1'b0, SRC_H, SRC_T, DST_T);
      4'd2:    u = mk_uop(FOP_ADD, 1'b0, SRC_X, SRC_T, DST_X);
      4'd3:    u = mk_uop(FOP_MUL, 1'b0, SRC_A, SRC_Y, DST_T);
      4'd4:    u = mk_uop(FOP_ADD, 1'b0, SRC_X, SRC_T, DST_T);
      4'd5:    u = mk_uop(FOP_MUL, 1'b0, SRC_H, SRC_T, DST_T);
      4'd6:    u = mk_uop(FOP_ADD, 1'b0, SRC_Y, SRC_T, DST_Y);
      4'd7:    u = mk_uop(FOP_SUB, 1'b0, SRC_X, SRC_C, DST_T);
      4'd8:    u = mk_uop(FOP_MUL, 1'b0, SRC_Z, SRC_T, DST_T);
      4'd9:    u = mk_uop(FOP_ADD, 1'b0, SRC_B, SRC_T, DST_T);
      4'd10:   u = mk_uop(FOP_MUL, 1'b0, SRC_H, SRC_T, DST_T);
      4'd11:   u = mk_uop(FOP_ADD, 1'b0, SRC_Z, SRC_T, DST_Z);
      default: u = mk_uop(FOP_SUB, 1'b1, SRC_Y, SRC_Z, DST_T);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- src/cap_fpu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cap_fpu (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cap_pkg::fpu_req_t req_i,
  output cap_pkg::fpu_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    F_IDLE, F_PRENORM, F_MUL, F_MULF, F_ALIGN, F_ADDS, F_NORM, F_DENORM, F_ROUND
  } fstate_e;

  fstate_e            state_q;
  logic               sgn_q, sb_q, sub_q, st_q, done_q;
  logic signed [13:0] exp_q, eb_q;
  logic [52:0]        ma_q, mb_q;
  logic [63:0]        rm_q, sm_q, res_q;
  logic [105:0]       acc_q;
  logic [1:0]         cnt_q;

  logic [10:0] ea_f, eb_f;
  logic [51:0] fa, fb;
  logic        sa, sb, sb_eff, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        spec;
  logic [63:0] spec_res;

  always_comb begin
    ea_f   = req_i.a[62:52];
    eb_f   = req_i.b[62:52];
    fa     = req_i.a[51:0];
    fb     = req_i.b[51:0];
    sa     = req_i.a[63];
    sb     = req_i.b[63];
    sb_eff = sb ^ (req_i.op == cap_pkg::FOP_SUB);
    a_nan  = (ea_f == 11'h7FF) && (fa != 52'd0);
    b_nan  = (eb_f == 11'h7FF) && (fb != 52'd0);
    a_inf  = (ea_f == 11'h7FF) && (fa == 52'd0);
    b_inf  = (eb_f == 11'h7FF) && (fb == 52'd0);
    a_zero = (ea_f == 11'd0) && (fa == 52'd0);
    b_zero = (eb_f == 11'd0) && (fb == 52'd0);
    spec     = 1'b1;
    spec_res = 64'd0;
    unique case (req_i.op)
      cap_pkg::FOP_CVT: begin
        spec = (req_i.a == 64'd0);
      end
      cap_pkg::FOP_MUL: begin
        if (a_nan) spec_res = req_i.a | cap_pkg::QNAN_BIT;
        else if (b_nan) spec_res = req_i.b | cap_pkg::QNAN_BIT;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = cap_pkg::DEF_NAN;
        else if (a_inf || b_inf) spec_res = {sa ^ sb, 11'h7FF, 52'd0};
        else if (a_zero || b_zero) spec_res = {sa ^ sb, 63'd0};
        else spec = 1'b0;
      end
      default: begin
        if (a_nan) spec_res = req_i.a | cap_pkg::QNAN_BIT;
        else if (b_nan) spec_res = req_i.b | cap_pkg::QNAN_BIT;
        else if (a_inf) spec_res = (b_inf && (sa != sb_eff)) ? cap_pkg::DEF_NAN : req_i.a;
        else if (b_inf) spec_res = {sb_eff, req_i.b[62:0]};
        else if (a_zero && b_zero) spec_res = {sa & sb_eff, 63'd0};
        else if (a_zero) spec_res = {sb_eff, req_i.b[62:0]};
        else if (b_zero) spec_res = req_i.a;
        else spec = 1'b0;
      end
    endcase
  end

  // alignment
  logic        a_ge, big_s;
  logic [52:0] big_m, sml_m;
  logic [10:0] big_e, sml_e, ediff;
  logic [63:0] sml_ext, sh, lost_mask, sm_d;
  logic        lost;

  always_comb begin
    a_ge    = {exp_q[10:0], ma_q} >= {eb_q[10:0], mb_q};
    big_m   = a_ge ? ma_q : mb_q;
    sml_m   = a_ge ? mb_q : ma_q;
    big_e   = a_ge ? exp_q[10:0] : eb_q[10:0];
    sml_e   = a_ge ? eb_q[10:0] : exp_q[10:0];
    big_s   = a_ge ? sgn_q : sb_q;
    ediff   = big_e - sml_e;
    sml_ext = {1'b0, sml_m, 10'd0};
    lost_mask = ~({64{1'b1}} << ediff[5:0]);
    if (ediff >= 11'd64) begin
      sh   = 64'd0;
      lost = |sml_m;
    end else begin
      sh   = sml_ext >> ediff[5:0];
      lost = |(sml_ext & lost_mask);
    end
    sm_d = {sh[63:1], sh[0] | lost};
  end

  // partial products
  logic [26:0]  px, py;
  logic [53:0]  prod;
  logic [105:0] pp;

  always_comb begin
    px = (cnt_q[1]) ? ma_q[52:26] : {1'b0, ma_q[25:0]};
    py = (cnt_q[0]) ? mb_q[52:26] : {1'b0, mb_q[25:0]};
    prod = px * py;
    case (cnt_q)
      2'd0:    pp = {52'd0, prod};
      2'd3:    pp = {prod, 52'd0};
      default: pp = {26'd0, prod, 26'd0};
    endcase
  end

  logic [63:0] sum;
  assign sum = sub_q ? (rm_q - sm_q) : (rm_q + sm_q);

  // rounding
  logic [52:0]        mant;
  logic [53:0]        mant_r;
  logic               rinc;
  logic signed [13:0] ef;
  logic [63:0]        rnd_res;

  always_comb begin
    mant   = rm_q[63:11];
    rinc   = rm_q[10] & ((|rm_q[9:0]) | st_q | mant[0]);
    mant_r = {1'b0, mant} + {53'd0, rinc};
    if (mant_r[53]) ef = exp_q + 14'sd1;
    else if (mant_r[52]) ef = exp_q;
    else ef = 14'sd0;
    if (ef >= 14'sd2047) rnd_res = {sgn_q, 11'h7FF, 52'd0};
    else rnd_res = {sgn_q, ef[10:0], mant_r[53] ? 52'd0 : mant_r[51:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
      sgn_q   <= 1'b0;
      sb_q    <= 1'b0;
      sub_q   <= 1'b0;
      st_q    <= 1'b0;
      exp_q   <= 14'sd0;
      eb_q    <= 14'sd0;
      ma_q    <= 53'd0;
      mb_q    <= 53'd0;
      rm_q    <= 64'd0;
      sm_q    <= 64'd0;
      res_q   <= 64'd0;
      acc_q   <= 106'd0;
      cnt_q   <= 2'd0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        F_IDLE: begin
          if (req_i.start) begin
            if (spec) begin
              res_q  <= spec_res;
              done_q <= 1'b1;
            end else begin
              ma_q  <= {ea_f != 11'd0, fa};
              mb_q  <= {eb_f != 11'd0, fb};
              exp_q <= {3'd0, (ea_f == 11'd0) ? 11'd1 : ea_f};
              eb_q  <= {3'd0, (eb_f == 11'd0) ? 11'd1 : eb_f};
              sb_q  <= sb_eff;
              st_q  <= 1'b0;
              unique case (req_i.op)
                cap_pkg::FOP_CVT: begin
                  rm_q    <= req_i.a;
                  exp_q   <= 14'sd1022;
                  sgn_q   <= 1'b0;
                  state_q <= F_NORM;
                end
                cap_pkg::FOP_MUL: begin
                  sgn_q   <= sa ^ sb;
                  state_q <= F_PRENORM;
                end
                default: begin
                  sgn_q   <= sa;
                  state_q <= F_ALIGN;
                end
              endcase
            end
          end
        end
        F_PRENORM: begin
          if (!ma_q[52]) begin
            ma_q  <= {ma_q[51:0], 1'b0};
            exp_q <= exp_q - 14'sd1;
          end else if (!mb_q[52]) begin
            mb_q <= {mb_q[51:0], 1'b0};
            eb_q <= eb_q - 14'sd1;
          end else begin
            acc_q   <= 106'd0;
            cnt_q   <= 2'd0;
            state_q <= F_MUL;
          end
        end
        F_MUL: begin
          acc_q <= acc_q + pp;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_q <= F_MULF;
        end
        F_MULF: begin
          rm_q    <= acc_q[105:42];
          st_q    <= |acc_q[41:0];
          exp_q   <= exp_q + eb_q - 14'sd1022;
          state_q <= F_NORM;
        end
        F_ALIGN: begin
          rm_q    <= {1'b0, big_m, 10'd0};
          sm_q    <= sm_d;
          exp_q   <= {3'd0, big_e} + 14'sd1;
          sgn_q   <= big_s;
          sub_q   <= sgn_q ^ sb_q;
          state_q <= F_ADDS;
        end
        F_ADDS: begin
          if (sum == 64'd0) begin
            res_q   <= 64'd0;
            done_q  <= 1'b1;
            state_q <= F_IDLE;
          end else begin
            rm_q    <= sum;
            state_q <= F_NORM;
          end
        end
        F_NORM: begin
          if (rm_q[63] || exp_q <= 14'sd1) begin
            state_q <= (exp_q < 14'sd1) ? F_DENORM : F_ROUND;
          end else if (exp_q > 14'sd16 && rm_q[63:48] == 16'd0) begin
            rm_q  <= {rm_q[47:0], 16'd0};
            exp_q <= exp_q - 14'sd16;
          end else begin
            rm_q  <= {rm_q[62:0], 1'b0};
            exp_q <= exp_q - 14'sd1;
          end
        end
        F_DENORM: begin
          if (exp_q >= 14'sd1) begin
            state_q <= F_ROUND;
          end else if (exp_q <= -14'sd63) begin
            st_q  <= st_q | (|rm_q);
            rm_q  <= 64'd0;
            exp_q <= 14'sd1;
          end else if (exp_q <= -14'sd15) begin
            st_q  <= st_q | (|rm_q[15:0]);
            rm_q  <= {16'd0, rm_q[63:16]};
            exp_q <= exp_q + 14'sd16;
          end else begin
            st_q  <= st_q | rm_q[0];
            rm_q  <= {1'b0, rm_q[63:1]};
            exp_q <= exp_q + 14'sd1;
          end
        end
        F_ROUND: begin
          res_q   <= rnd_res;
          done_q  <= 1'b1;
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  a_done_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == F_ROUND || $past(state_q) == F_ADDS
                || $past(state_q) == F_IDLE))
    else $error("fpu done from unexpected state");
  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_MULF) |-> ($past(state_q) == F_MUL && cnt_q == 2'd0))
    else $error("partial product count broken");
  a_round_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_ROUND) |-> exp_q >= 14'sd1)
    else $error("rounding entered with exponent below one");

endmodule

`default_nettype wire

// ----- src/chaotic_attractor_prng.sv -----
// Seed item: three unsigned 0.64 fixed-point-to-double conversions, then DISCARD_STEPS-1
//   Euler steps, each 12 passes through the shared floating-point unit; a zero or special
//   operand is resolved without the arithmetic states, while cancellation or subnormals
//   add normalisation steps.
// Generate item: one Euler step plus mixing (an add step, then MIX_ROUNDS rotate-xor rounds).
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Reset: asynchronous, active low; clears x, y, z and all registers to +0.0.
`timescale 1ns / 1ps
`default_nettype none

module chaotic_attractor_prng (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [191:0] s_axis_tdata,  // seed_x, seed_y, seed_z
  input  wire          s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // random_word
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [63:0]  cfg_data_i
);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_MIX0, S_MIXR, S_FIN} state_e;

  state_e state_q;
  logic   cvt_q, gen_q, out_valid_q;
  logic [1:0]                  idx_q;
  logic [cap_pkg::UOP_W-1:0]   uop_q;
  logic [cap_pkg::STEP_W-1:0]  steps_q;
  logic [cap_pkg::RND_W-1:0]   rnd_q;
  logic [63:0] seed_q [3];
  logic [63:0] x_q, y_q, z_q, t_q, h_q, a_q, b_q, c_q;
  logic [31:0] w_q [6];
  logic [31:0] out_q;

  cap_pkg::uop_t     uop;
  cap_pkg::fpu_req_t req;
  cap_pkg::fpu_rsp_t rsp;

  function automatic logic [63:0] pick(cap_pkg::src_e s, logic [63:0] x, logic [63:0] y,
                                       logic [63:0] z, logic [63:0] t, logic [63:0] h,
                                       logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [63:0] v;
    unique case (s)
      cap_pkg::SRC_X: v = x;
      cap_pkg::SRC_Y: v = y;
      cap_pkg::SRC_Z: v = z;
      cap_pkg::SRC_T: v = t;
      cap_pkg::SRC_H: v = h;
      cap_pkg::SRC_A: v = a;
      cap_pkg::SRC_B: v = b;
      default:        v = c;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  always_comb begin
    uop       = cap_pkg::uop_at(uop_q);
    req.start = (state_q == S_ISSUE);
    req.op    = cvt_q ? cap_pkg::FOP_CVT : uop.op;
    req.a     = cvt_q ? seed_q[idx_q]
              : (pick(uop.a, x_q, y_q, z_q, t_q, h_q, a_q, b_q, c_q)
                 ^ {uop.neg_a, 63'd0});
    req.b     = pick(uop.b, x_q, y_q, z_q, t_q, h_q, a_q, b_q, c_q);
  end

  cap_fpu u_fpu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  logic [31:0] r0, r3, r5, r1, r2, r4;
  always_comb begin
    r0 = rotl(w_q[0], cap_pkg::ROT_A);
    r3 = rotl(w_q[3], cap_pkg::ROT_B);
    r5 = w_q[5] ^ (w_q[4] + r3);
    r1 = w_q[1] ^ (w_q[2] + r0);
    r2 = w_q[2] ^ r0 ^ r5;
    r4 = w_q[4] ^ r3 ^ r1;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cvt_q       <= 1'b0;
      gen_q       <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      uop_q       <= '0;
      steps_q     <= '0;
      rnd_q       <= '0;
      seed_q[0]   <= 64'd0;
      seed_q[1]   <= 64'd0;
      seed_q[2]   <= 64'd0;
      w_q[0]      <= 32'd0;
      w_q[1]      <= 32'd0;
      w_q[2]      <= 32'd0;
      w_q[3]      <= 32'd0;
      w_q[4]      <= 32'd0;
      w_q[5]      <= 32'd0;
      out_q       <= 32'd0;
      x_q <= 64'd0;
      y_q <= 64'd0;
      z_q <= 64'd0;
      t_q <= 64'd0;
      h_q <= 64'd0;
      a_q <= 64'd0;
      b_q <= 64'd0;
      c_q <= 64'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cap_pkg::cfg_idx_e'(cfg_idx_i))
          cap_pkg::CFG_STEP: h_q <= cfg_data_i;
          cap_pkg::CFG_A:    a_q <= cfg_data_i;
          cap_pkg::CFG_B:    b_q <= cfg_data_i;
          default:           c_q <= cfg_data_i;
        endcase
      end
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            uop_q <= '0;
            idx_q <= 2'd0;
            if (!s_axis_tuser) begin
              seed_q[0] <= s_axis_tdata[63:0];
              seed_q[1] <= s_axis_tdata[127:64];
              seed_q[2] <= s_axis_tdata[191:128];
              cvt_q     <= 1'b1;
              gen_q     <= 1'b0;
            end else begin
              w_q[0]  <= {12'd0, x_q[51:32]};
              w_q[1]  <= x_q[31:0];
              w_q[2]  <= {12'd0, y_q[51:32]};
              w_q[3]  <= y_q[31:0];
              w_q[4]  <= {12'd0, z_q[51:32]};
              w_q[5]  <= z_q[31:0];
              cvt_q   <= 1'b0;
              gen_q   <= 1'b1;
              steps_q <= cap_pkg::STEP_W'(1);
            end
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            if (cvt_q) begin
              unique case (idx_q)
                2'd0:    x_q <= rsp.res;
                2'd1:    y_q <= rsp.res;
                default: z_q <= rsp.res;
              endcase
              idx_q <= idx_q + 2'd1;
              if (idx_q == 2'd2) begin
                cvt_q   <= 1'b0;
                steps_q <= cap_pkg::STEP_W'(cap_pkg::DISCARD_STEPS - 1);
                state_q <= (cap_pkg::DISCARD_STEPS == 1) ? S_IDLE : S_ISSUE;
              end else begin
                state_q <= S_ISSUE;
              end
            end else begin
              unique case (uop.dst)
                cap_pkg::DST_X: x_q <= rsp.res;
                cap_pkg::DST_Y: y_q <= rsp.res;
                cap_pkg::DST_Z: z_q <= rsp.res;
                default:        t_q <= rsp.res;
              endcase
              if (uop_q == cap_pkg::UOP_W'(cap_pkg::NUM_UOPS - 1)) begin
                uop_q <= '0;
                if (steps_q == cap_pkg::STEP_W'(1)) begin
                  state_q <= gen_q ? S_MIX0 : S_IDLE;
                end else begin
                  steps_q <= steps_q - cap_pkg::STEP_W'(1);
                  state_q <= S_ISSUE;
                end
              end else begin
                uop_q   <= uop_q + cap_pkg::UOP_W'(1);
                state_q <= S_ISSUE;
              end
            end
          end
        end
        S_MIX0: begin
          w_q[0]  <= w_q[0] + w_q[1];
          w_q[2]  <= w_q[2] + w_q[3];
          w_q[4]  <= w_q[4] + w_q[5];
          rnd_q   <= '0;
          state_q <= S_MIXR;
        end
        S_MIXR: begin
          w_q[0] <= r0;
          w_q[1] <= r1;
          w_q[2] <= r2;
          w_q[3] <= r3;
          w_q[4] <= r4;
          w_q[5] <= r5;
          rnd_q  <= rnd_q + cap_pkg::RND_W'(1);
          if (rnd_q == cap_pkg::RND_W'(cap_pkg::MIX_ROUNDS - 1)) state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q       <= w_q[2] + w_q[4];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside final state");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == S_WAIT)
    else $error("fpu finished while sequencer not waiting");
  a_steps_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE && !cvt_q) |-> steps_q != '0)
    else $error("step issued with no steps left");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !m_axis_tready) |=> state_q == S_FIN)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
